@@ rtl/core/srgblab_pkg.sv @@
package srgblab_pkg;

	localparam int XYZ_FRAC_DEF = 15;
	localparam int LAB_FRAC_DEF = 7;

	// Q31 values with one integer bit (1.0 = 2^31)
	localparam int Q_W = 32;
	localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

	localparam int LIN_PROD_W = 52;
	localparam int SUM_W = 54;

	localparam logic [63:0] WHITE_SCALE = 64'd100000;
	localparam logic [63:0] WHITE_X = 64'd95047;
	localparam logic [63:0] WHITE_Z = 64'd108883;
	localparam logic [63:0] LIN_SLOPE = 64'd24389;
	localparam logic [63:0] LIN_OFFSET = 64'd432 << 31;
	localparam logic [63:0] LIN_DIV = 64'd3132;
	localparam logic [63:0] KNEE = 64'd216 << 31;

	// register stages of the constant divider and cube-root units
	localparam int DIV_LAT = 2;
	localparam int CBRT_LAT = Q_W + 1;
	localparam int COMP_LAT = CBRT_LAT + 2;

	typedef logic [Q_W-1:0] q31_t;
	typedef q31_t lin_lut_t [256];
	typedef logic [19:0] coef_t;

	localparam coef_t MAT [3][3] = '{
		'{20'd432492, 20'd374946, 20'd189202},
		'{20'd223004, 20'd749891, 20'd75681},
		'{20'd20273, 20'd124982, 20'd996466}
	};

	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p >> 31;
	endfunction

	function automatic logic [63:0] pow5q(input logic [63:0] r);
		logic [63:0] a;
		a = r;
		for (int i = 0; i < 4; i++) begin
			a = mulq(a, r);
		end
		return a;
	endfunction

	function automatic logic [63:0] root5q(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand <= ONE_Q31 && pow5q(cand) <= v) begin
				r = cand;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] lin_of(input logic [63:0] c);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] res;
		if (c <= 64'd10) begin
			res = ((c * 64'd10) << 31) / 64'd32946;
		end else begin
			t = ((64'd40 * c + 64'd561) << 31) / 64'd10761;
			t2 = mulq(t, t);
			res = mulq(t2, root5q(t2));
		end
		return res;
	endfunction

	function automatic lin_lut_t build_lut();
		lin_lut_t lut;
		for (int c = 0; c < 256; c++) begin
			lut[c] = Q_W'(lin_of(64'(c)));
		end
		return lut;
	endfunction

	// sRGB code to linear light, Q31
	localparam lin_lut_t LIN_LUT = build_lut();

endpackage

@@ rtl/core/srgblab_rgb_if.sv @@
interface srgblab_rgb_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/core/srgblab_lab_if.sv @@
interface srgblab_lab_if;
	logic valid;
	logic ready;
	logic [15:0] x_value;
	logic [15:0] y_value;
	logic [15:0] z_value;
	logic [13:0] lightness;
	logic signed [14:0] green_red;
	logic signed [14:0] blue_yellow;

	modport source (output valid, output x_value, output y_value, output z_value,
		output lightness, output green_red, output blue_yellow, input ready);
	modport sink (input valid, input x_value, input y_value, input z_value,
		input lightness, input green_red, input blue_yellow, output ready);
endinterface

@@ rtl/core/srgb_to_cielab.sv @@
// sRGB (8 bits a channel) to CIE XYZ (Q1.15 by default) and CIELAB (units of 1/128 by
// default) for the D65 white point. The block is a fully pipelined stream: one pixel
// transaction may be accepted every clock cycle while the pipeline is not held, and the
// depth is set mostly by the 33-stage cube-root unit in the companding step; the white
// normalisation is a two-stage reciprocal multiplication. The whole pipeline
// advances together; it holds when the output register is full and not taken, so a
// stalled transaction is neither lost nor repeated.
module srgb_to_cielab
	import srgblab_pkg::*;
#(
	parameter int XYZ_FRAC_BITS = XYZ_FRAC_DEF,
	parameter int LAB_FRAC_BITS = LAB_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	srgblab_rgb_if.sink   pix,
	srgblab_lab_if.source lab
);

	localparam int XSH = 51 - XYZ_FRAC_BITS;
	localparam logic [63:0] XHALF = 64'd1 << (XSH - 1);
	localparam int LSH = 31 - LAB_FRAC_BITS;
	localparam logic [63:0] LHALF = 64'd1 << (LSH - 1);
	// register stages from the XYZ rounding stage to the output register
	localparam int DLY = DIV_LAT + COMP_LAT + 2;
	localparam int NST = 4 + DLY;

	logic           en;
	logic [NST-1:0] vld_q;

	q31_t                  lin_s1  [3];
	logic [LIN_PROD_W-1:0] prod_s2 [3][3];
	logic [SUM_W-1:0]      sum_s3  [3];
	logic [15:0]           xyz_s4  [3];
	q31_t                  q31_s4  [3];
	q31_t                  ratio   [3];
	q31_t                  f       [3];
	logic [15:0]           xyz_dly [DLY][3];

	logic [38:0]        lv_s5;
	logic signed [41:0] da_s5;
	logic signed [41:0] db_s5;
	logic [13:0]        l_s6;
	logic [14:0]        a_s6;
	logic [14:0]        b_s6;

	// the whole pipe moves when the output slot is free or being taken
	assign en = !vld_q[NST-1] || lab.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pix.valid};
		end
	end

	// stage 1: linearise each channel from the gamma table
	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= LIN_LUT[pix.red];
			lin_s1[1] <= LIN_LUT[pix.green];
			lin_s1[2] <= LIN_LUT[pix.blue];
		end
	end

	// stage 2: matrix products, Q20 coefficient by Q31 channel
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= LIN_PROD_W'(MAT[i][j]) * LIN_PROD_W'(lin_s1[j]);
				end
			end
		end
	end

	// stage 3: row sums, Q51
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sum_s3[i] <= SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1])
					+ SUM_W'(prod_s2[i][2]);
			end
		end
	end

	// stage 4: round to the XYZ output format and to Q31 for the Lab path
	always_ff @(posedge clk) begin
		logic [63:0] xr;
		logic [63:0] qr;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				xr = (64'(sum_s3[i]) + XHALF) >> XSH;
				qr = (64'(sum_s3[i]) + (64'd1 << 19)) >> 20;
				xyz_s4[i] <= (xr > 64'd65535) ? 16'hFFFF : xr[15:0];
				q31_s4[i] <= qr[Q_W-1:0];
			end
		end
	end

	// normalise by the reference white; Y is passed through the same depth
	srgblab_cdiv #(
		.IN_W    (Q_W),
		.QUO_W   (Q_W),
		.MULT    (WHITE_SCALE),
		.ADD     (64'd0),
		.DIVISOR (WHITE_X)
	) u_div_x (
		.clk (clk),
		.en  (en),
		.a   (q31_s4[0]),
		.quo (ratio[0])
	);

	srgblab_cdiv #(
		.IN_W    (Q_W),
		.QUO_W   (Q_W),
		.MULT    (64'd1),
		.ADD     (64'd0),
		.DIVISOR (64'd1)
	) u_div_y (
		.clk (clk),
		.en  (en),
		.a   (q31_s4[1]),
		.quo (ratio[1])
	);

	srgblab_cdiv #(
		.IN_W    (Q_W),
		.QUO_W   (Q_W),
		.MULT    (WHITE_SCALE),
		.ADD     (64'd0),
		.DIVISOR (WHITE_Z)
	) u_div_z (
		.clk (clk),
		.en  (en),
		.a   (q31_s4[2]),
		.quo (ratio[2])
	);

	for (genvar i = 0; i < 3; i++) begin : g_comp
		srgblab_compand u_comp (
			.clk   (clk),
			.en    (en),
			.ratio (ratio[i]),
			.f     (f[i])
		);
	end

	// carry XYZ alongside the Lab path; the last entry is the output register
	always_ff @(posedge clk) begin
		if (en) begin
			xyz_dly[0] <= xyz_s4;
			for (int d = 1; d < DLY; d++) begin
				xyz_dly[d] <= xyz_dly[d-1];
			end
		end
	end

	// stage after companding: L*, a*, b* in Q31
	always_ff @(posedge clk) begin
		if (en) begin
			lv_s5 <= 39'd116 * 39'(f[1]) - (39'd16 << 31);
			da_s5 <= 42'sd500 * ($signed({10'd0, f[0]}) - $signed({10'd0, f[1]}));
			db_s5 <= 42'sd200 * ($signed({10'd0, f[1]}) - $signed({10'd0, f[2]}));
		end
	end

	// round half away from zero and saturate to the signed output range
	function automatic logic [14:0] lab_round(input logic signed [41:0] v);
		logic [63:0] mag;
		logic [63:0] m;
		logic [14:0] ms;
		mag = v[41] ? 64'(-v) : 64'(v);
		m = (mag + LHALF) >> LSH;
		if (v[41]) begin
			ms = (m > 64'd16384) ? 15'h4000 : m[14:0];
			return ~ms + 15'd1;
		end else begin
			return (m > 64'd16383) ? 15'h3FFF : m[14:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		logic [38:0] ls;
		logic [63:0] lr;
		if (en) begin
			// black lands a few LSBs below zero; let the sum wrap so it rounds to zero
			ls = lv_s5 + LHALF[38:0];
			lr = 64'(ls >> LSH);
			l_s6 <= (lr > 64'd16383) ? 14'h3FFF : lr[13:0];
			a_s6 <= lab_round(da_s5);
			b_s6 <= lab_round(db_s5);
		end
	end

	assign lab.valid = vld_q[NST-1];
	assign lab.x_value = xyz_dly[DLY-1][0];
	assign lab.y_value = xyz_dly[DLY-1][1];
	assign lab.z_value = xyz_dly[DLY-1][2];
	assign lab.lightness = l_s6;
	assign lab.green_red = $signed(a_s6);
	assign lab.blue_yellow = $signed(b_s6);

	// a stall freezes occupancy
	assert property (@(posedge clk) disable iff (!arst_n) !en |=> $stable(vld_q))
		else $error("pipeline occupancy changed during a stall");

	// when advancing, each valid bit moves exactly one stage
	assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_q[NST-1:1] == $past(vld_q[NST-2:0]))
		else $error("valid bit lost or duplicated between stages");

	// nothing is accepted while the full output register is held
	assert property (@(posedge clk) disable iff (!arst_n)
		lab.valid && !lab.ready |-> !pix.ready)
		else $error("input taken while the pipeline is stalled");

endmodule

@@ rtl/core/srgblab_cdiv.sv @@
// Constant divider: quo = floor((a * MULT + ADD) / DIVISOR) by reciprocal multiplication.
// The reciprocal carries enough fraction bits that its error stays below 1/DIVISOR over
// every a under 2^IN_W, so the quotient is exact. Split the product in two halves.
module srgblab_cdiv
	import srgblab_pkg::*;
#(
	parameter int IN_W = 32,
	parameter int QUO_W = 32,
	parameter logic [63:0] MULT = 64'd1,
	parameter logic [63:0] ADD = 64'd0,
	parameter logic [63:0] DIVISOR = 64'd1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  a,
	output logic [QUO_W-1:0] quo
);

	localparam int SH = IN_W + $clog2(DIVISOR);
	localparam logic [127:0] RM =
		((128'(MULT) << SH) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
	localparam logic [127:0] RC =
		((128'(ADD) << SH) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
	localparam int M_W = $clog2(RM + 128'd1);
	localparam int LO_W = (M_W + 1) / 2;
	localparam int HI_W = M_W - LO_W;
	localparam logic [LO_W-1:0] M_LO = RM[LO_W-1:0];
	localparam logic [HI_W-1:0] M_HI = RM[M_W-1:LO_W];

	logic [IN_W+LO_W-1:0] plo_s1;
	logic [IN_W+HI_W-1:0] phi_s1;
	logic [127:0]         acc;
	logic [QUO_W-1:0]     quo_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= (IN_W+LO_W)'(a) * (IN_W+LO_W)'(M_LO);
			phi_s1 <= (IN_W+HI_W)'(a) * (IN_W+HI_W)'(M_HI);
		end
	end

	assign acc = (128'(phi_s1) << LO_W) + 128'(plo_s1) + RC;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= acc[SH +: QUO_W];
		end
	end

	assign quo = quo_s2;

endmodule

@@ rtl/core/srgblab_cbrt.sv @@
// Cube root in Q31: largest r <= 1.0 whose truncated cube is <= v, one bit a stage
module srgblab_cbrt
	import srgblab_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  q31_t v,
	output q31_t root
);

	q31_t        v_s  [Q_W+1];
	q31_t        r_s  [Q_W+1];
	logic [63:0] r2_s [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0] <= v;
			r_s[0] <= '0;
			r2_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int B = Q_W - 1 - k;
		q31_t        cand;
		logic [63:0] sq;
		logic [32:0] sqt;
		logic [65:0] cube;
		logic        take;

		always_comb begin
			cand = r_s[k] | (q31_t'(1) << B);
			// exact square of the candidate from the kept square of r
			sq = r2_s[k] + (64'(r_s[k]) << (B + 1)) + (64'd1 << (2 * B));
			sqt = sq[63:31];
			cube = (66'(sqt) * 66'(cand)) >> 31;
			take = (64'(cand) <= ONE_Q31) && (cube <= 66'(v_s[k]));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k+1] <= v_s[k];
				r_s[k+1] <= take ? cand : r_s[k];
				r2_s[k+1] <= take ? sq : r2_s[k];
			end
		end
	end

	assign root = r_s[Q_W];

endmodule

@@ rtl/core/srgblab_compand.sv @@
// Lab companding: clamp to white, then cube root or linear segment
module srgblab_compand
	import srgblab_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  q31_t ratio,
	output q31_t f
);

	localparam int LIN_PAD = CBRT_LAT - DIV_LAT;

	q31_t t_s1;
	logic cube_s1;
	logic cube_dly [CBRT_LAT];
	q31_t lin_dly [LIN_PAD];
	q31_t root;
	q31_t lin;
	q31_t f_q;
	q31_t t_c;

	assign t_c = (64'(ratio) > ONE_Q31) ? q31_t'(ONE_Q31) : ratio;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_c;
			cube_s1 <= (64'(t_c) * LIN_SLOPE) > KNEE;
		end
	end

	srgblab_cbrt u_cbrt (
		.clk  (clk),
		.en   (en),
		.v    (t_s1),
		.root (root)
	);

	srgblab_cdiv #(
		.IN_W    (Q_W),
		.QUO_W   (Q_W),
		.MULT    (LIN_SLOPE),
		.ADD     (LIN_OFFSET),
		.DIVISOR (LIN_DIV)
	) u_lin (
		.clk (clk),
		.en  (en),
		.a   (t_s1),
		.quo (lin)
	);

	// hold the segment choice and the linear value alongside the root pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			cube_dly[0] <= cube_s1;
			for (int i = 1; i < CBRT_LAT; i++) begin
				cube_dly[i] <= cube_dly[i-1];
			end
			lin_dly[0] <= lin;
			for (int i = 1; i < LIN_PAD; i++) begin
				lin_dly[i] <= lin_dly[i-1];
			end
			f_q <= cube_dly[CBRT_LAT-1] ? root : lin_dly[LIN_PAD-1];
		end
	end

	assign f = f_q;

endmodule

@@ tb/sv/srgblab_scoreboard.sv @@
`timescale 1ns / 1ps

module srgblab_scoreboard
	import srgblab_pkg::*;
#(
	parameter int XYZ_FRAC_BITS = XYZ_FRAC_DEF,
	parameter int LAB_FRAC_BITS = LAB_FRAC_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	srgblab_rgb_if pix,
	srgblab_lab_if lab,
	output int     mismatches,
	output int     pending
);

	typedef struct packed {
		logic [15:0] x_value;
		logic [15:0] y_value;
		logic [15:0] z_value;
		logic [13:0] lightness;
		logic [14:0] green_red;
		logic [14:0] blue_yellow;
	} lab_pixel_t;

	localparam logic [63:0] UNITY = 64'd1 << 31;

	lab_pixel_t lab_due [$];

	function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> 31;
	endfunction

	// largest Q31 root not above one whose truncated fifth power fits under v
	function automatic logic [63:0] fifth_root(input logic [63:0] v);
		logic [63:0] acc, trial, p;
		acc = '0;
		for (int k = 31; k >= 0; k--) begin
			trial = acc | (64'd1 << k);
			p = trial;
			for (int n = 0; n < 4; n++)
				p = q_mul(p, trial);
			if (trial <= UNITY && p <= v)
				acc = trial;
		end
		return acc;
	endfunction

	function automatic logic [63:0] cube_root(input logic [63:0] v);
		logic [63:0] acc, trial;
		acc = '0;
		for (int k = 31; k >= 0; k--) begin
			trial = acc | (64'd1 << k);
			if (trial <= UNITY && q_mul(q_mul(trial, trial), trial) <= v)
				acc = trial;
		end
		return acc;
	endfunction

	function automatic logic [63:0] gamma_expand(input logic [7:0] code);
		logic [63:0] c, t, t2;
		c = 64'(code);
		if (c <= 64'd10)
			return ((c * 64'd10) << 31) / 64'd32946;
		t = ((64'd40 * c + 64'd561) << 31) / 64'd10761;
		t2 = q_mul(t, t);
		return q_mul(t2, fifth_root(t2));
	endfunction

	function automatic logic [63:0] lab_compand(input logic [63:0] ratio);
		logic [63:0] t;
		// clamp a ratio above the white point
		t = (ratio > UNITY) ? UNITY : ratio;
		if (t * 64'd24389 > (64'd216 << 31))
			return cube_root(t);
		return (64'd24389 * t + (64'd432 << 31)) / 64'd3132;
	endfunction

	function automatic logic [14:0] round_axis(input logic signed [63:0] v);
		int sh;
		logic [63:0] mag, half;
		sh = 31 - LAB_FRAC_BITS;
		half = 64'd1 << (sh - 1);
		if (v < 0) begin
			mag = (64'(-v) + half) >> sh;
			if (mag > 64'd16384)
				mag = 64'd16384;
			return 15'(-mag);
		end
		mag = (64'(v) + half) >> sh;
		if (mag > 64'd16383)
			mag = 64'd16383;
		return 15'(mag);
	endfunction

	function automatic lab_pixel_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [63:0] lin [3];
		logic [63:0] acc [3];
		logic [63:0] q [3];
		logic [63:0] f [3];
		logic [63:0] xyz [3];
		logic [63:0] lv, lr;
		int xsh;
		lab_pixel_t res;
		xsh = 51 - XYZ_FRAC_BITS;
		lin[0] = gamma_expand(r);
		lin[1] = gamma_expand(g);
		lin[2] = gamma_expand(b);
		for (int i = 0; i < 3; i++) begin
			acc[i] = 64'(MAT[i][0]) * lin[0] + 64'(MAT[i][1]) * lin[1]
				+ 64'(MAT[i][2]) * lin[2];
			xyz[i] = (acc[i] + (64'd1 << (xsh - 1))) >> xsh;
			if (xyz[i] > 64'd65535)
				xyz[i] = 64'd65535;
			q[i] = (acc[i] + (64'd1 << 19)) >> 20;
		end
		f[0] = lab_compand((q[0] * 64'd100000) / 64'd95047);
		f[1] = lab_compand(q[1]);
		f[2] = lab_compand((q[2] * 64'd100000) / 64'd108883);
		lv = 64'd116 * f[1] - (64'd16 << 31);
		lr = (lv + (64'd1 << (30 - LAB_FRAC_BITS))) >> (31 - LAB_FRAC_BITS);
		if (lr > 64'd16383)
			lr = 64'd16383;
		res.x_value = xyz[0][15:0];
		res.y_value = xyz[1][15:0];
		res.z_value = xyz[2][15:0];
		res.lightness = lr[13:0];
		res.green_red = round_axis(64'sd500 * ($signed(f[0]) - $signed(f[1])));
		res.blue_yellow = round_axis(64'sd200 * ($signed(f[1]) - $signed(f[2])));
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
		mismatches++;
	endtask

	initial mismatches = 0;
	assign pending = lab_due.size();

	always @(posedge clk) begin
		lab_pixel_t want;
		if (arst_n) begin
			if (pix.valid && pix.ready)
				lab_due.push_back(convert_pixel(pix.red, pix.green, pix.blue));
			if (lab.valid && lab.ready) begin
				if (lab_due.size() == 0) begin
					$display("[%0t] result transaction with nothing outstanding", $realtime);
					mismatches++;
				end else begin
					want = lab_due.pop_front();
					if (lab.x_value !== want.x_value)
						report_mismatch("x_value", lab.x_value, want.x_value);
					if (lab.y_value !== want.y_value)
						report_mismatch("y_value", lab.y_value, want.y_value);
					if (lab.z_value !== want.z_value)
						report_mismatch("z_value", lab.z_value, want.z_value);
					if (lab.lightness !== want.lightness)
						report_mismatch("lightness", 16'(lab.lightness), 16'(want.lightness));
					if (lab.green_red !== want.green_red)
						report_mismatch("green_red", 16'(lab.green_red), 16'(want.green_red));
					if (lab.blue_yellow !== want.blue_yellow)
						report_mismatch("blue_yellow", 16'(lab.blue_yellow),
							16'(want.blue_yellow));
				end
			end
		end
	end

endmodule

@@ tb/sv/tb_srgb_to_cielab.sv @@
`timescale 1ns / 1ps

module tb_srgb_to_cielab;
	import srgblab_pkg::*;

	localparam int RANDOM_PIXELS = 1250;
	localparam int DRAIN_CYCLES = 200;	// comfortably above the pipeline latency
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_OFF_CYCLES = 400;

	logic clk;
	logic arst_n;
	int mismatches;
	int pending;
	int cycles;
	bit gaps_on;		// random idling on both sides
	bit hold_request;	// ask the receiver for one long hold-off

	srgblab_rgb_if pix ();
	srgblab_lab_if lab ();

	srgb_to_cielab uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix.sink),
		.lab(lab.source)
	);

	srgblab_scoreboard scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.lab(lab),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop: counts every cycle from time zero.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** srgb_to_cielab: FAILED **");
			$finish;
		end
	end

	// Receiver: stall at random while gaps are on; hold off for a long stretch on
	// request so that the pipeline fills and pushes back on the pixel input.
	always @(posedge clk) begin
		if (hold_request) begin
			lab.ready <= 1'b0;
			for (int n = 0; n < HOLD_OFF_CYCLES; n++)
				@(posedge clk);
			hold_request <= 1'b0;
		end
		lab.ready <= !(gaps_on && $urandom_range(0, 99) < 37);
	end

	// Offer one pixel transaction and hold it until taken; idle first at random.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (gaps_on && $urandom_range(0, 99) < 37) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.red <= r;
		pix.green <= g;
		pix.blue <= b;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
	endtask

	// Pause the sender until the block has handed back every outstanding result.
	task automatic drain_results();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Pick a channel code, weighting the extremes and the gamma knee.
	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(8, 13));
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [7:0] r, g, b;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		hold_request = 1'b0;
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		lab.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: black, white, primaries, greys, both sides of the gamma knee,
		// saturated hues whose ratios reach the white point, single-bit codes.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd10, 8'd10, 8'd10);
		send_pixel(8'd11, 8'd11, 8'd11);
		send_pixel(8'd10, 8'd11, 8'd12);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd170, 8'd85, 8'd170);
		send_pixel(8'd85, 8'd170, 8'd85);
		send_pixel(8'd254, 8'd254, 8'd254);
		send_pixel(8'd255, 8'd254, 8'd253);
		send_pixel(8'd2, 8'd4, 8'd8);
		drain_results();

		// Random: unthrottled first, then with idling, pressure in the middle.
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			if (n == 250)
				gaps_on = 1'b1;
			if (n == 500)
				hold_request <= 1'b1;
			if (n == 800)
				drain_results();
			r = pick_code();
			g = pick_code();
			b = pick_code();
			send_pixel(r, g, b);
		end
		pix.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** srgb_to_cielab: PASSED **");
		else
			$display("** srgb_to_cielab: FAILED **");
		$finish;
	end

endmodule
